// File: sv/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg - shared types and constants for the nearest palette colour search
// Item kinds, search states, the probe that moves down the cell row and the
// widths of the stream payloads.
// ----------------------------------------------------------------------------
package npc_pkg;

   localparam int NPC_ENTRIES_DEFAULT = 256;
   localparam int NPC_INDEX_W         = 8;
   localparam int NPC_CHAN_W          = 8;
   localparam int NPC_SQ_W            = 2 * NPC_CHAN_W;
   localparam int NPC_DIST_W          = 18;
   localparam int NPC_REQ_DATA_W      = NPC_INDEX_W + 3 * NPC_CHAN_W;
   localparam int NPC_RSP_DATA_W      = NPC_INDEX_W;

   // above any reachable distance, so entry 0 always wins first
   localparam logic [NPC_DIST_W-1:0] NPC_DIST_START = 18'd196608;

   typedef enum logic {
      NPC_REQ_LOAD  = 1'b0,
      NPC_REQ_QUERY = 1'b1
   } npc_req_type;

   typedef enum logic {
      NPC_IDLE   = 1'b0,
      NPC_SEARCH = 1'b1
   } npc_state_type;

   typedef struct packed {
      logic [NPC_CHAN_W-1:0] red;
      logic [NPC_CHAN_W-1:0] green;
      logic [NPC_CHAN_W-1:0] blue;
   } npc_rgb_type;

   typedef struct packed {
      logic                   valid;
      npc_rgb_type            colour;
      logic [NPC_DIST_W-1:0]  best_dist;
      logic [NPC_INDEX_W-1:0] best_idx;
   } npc_probe_type;

endpackage

// File: sv/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell - one palette entry with its distance compare
// Holds one entry, measures the passing query colour against it and hands the
// updated best distance and index to the next cell through a register.
// ----------------------------------------------------------------------------
module npc_cell
   import npc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  npc_rgb_type   wr_rgb,
   input  npc_probe_type up_probe,
   output npc_probe_type dn_probe
);

   npc_rgb_type           entry_ff;
   npc_probe_type         probe_ff;
   npc_probe_type         probe_in;
   logic [NPC_SQ_W-1:0]   sq_red;
   logic [NPC_SQ_W-1:0]   sq_green;
   logic [NPC_SQ_W-1:0]   sq_blue;
   logic [NPC_DIST_W-1:0] cell_gap;

   function automatic logic [NPC_SQ_W-1:0] chan_sq(input logic [NPC_CHAN_W-1:0] a,
                                                   input logic [NPC_CHAN_W-1:0] b);
      logic [NPC_CHAN_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return NPC_SQ_W'(d) * NPC_SQ_W'(d);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_rgb;
      end
   end

   always_comb begin
      sq_red   = chan_sq(entry_ff.red,   up_probe.colour.red);
      sq_green = chan_sq(entry_ff.green, up_probe.colour.green);
      sq_blue  = chan_sq(entry_ff.blue,  up_probe.colour.blue);
      cell_gap = NPC_DIST_W'(sq_red) + NPC_DIST_W'(sq_green) + NPC_DIST_W'(sq_blue);
   end

   // replace only on a strictly smaller distance: ties keep the lower index
   always_comb begin
      probe_in = up_probe;
      if (cell_gap < up_probe.best_dist) begin
         probe_in.best_dist = cell_gap;
         probe_in.best_idx  = NPC_INDEX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.colour    <= probe_in.colour;
      probe_ff.best_dist <= probe_in.best_dist;
      probe_ff.best_idx  <= probe_in.best_idx;
   end

   assign dn_probe = probe_ff;

endmodule

// File: sv/npc_chain.sv
// ----------------------------------------------------------------------------
// npc_chain - row of palette cells
// Decodes load writes to one cell and passes a query probe from cell 0 to the
// last cell, one cell per cycle.
// ----------------------------------------------------------------------------
module npc_chain
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = NPC_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_en,
   input  logic [NPC_INDEX_W-1:0] load_index,
   input  npc_rgb_type            load_rgb,
   input  npc_probe_type          head_probe,
   output npc_probe_type          tail_probe
);

   npc_probe_type              link [PALETTE_ENTRIES+1];
   logic [PALETTE_ENTRIES-1:0] cell_wr;

   assign link[0] = head_probe;

   // an index at or beyond the palette size matches no cell and is dropped
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      assign cell_wr[i] = load_en && (load_index == NPC_INDEX_W'(i));

      npc_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (cell_wr[i]),
         .wr_rgb   (load_rgb),
         .up_probe (link[i]),
         .dn_probe (link[i+1])
      );
   end

   assign tail_probe = link[PALETTE_ENTRIES];

endmodule

// File: sv/nearest_palette_colour_euclid_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_colour_euclid_top - nearest palette colour search
//
//   port group  dir  tdata (low bit up)                     tuser
//   req_        in   entry_index, red, green, blue          0 load, 1 query
//   rsp_        out  nearest_index                          -
//
// A load writes one cell; it gives no item back.
// A query walks the cell row one cell per cycle and its result is then
// registered in the output buffer; the next item can be taken once the
// search state has returned to idle.
// No item is accepted while a query is in the row.
// Results wait in a two-deep output buffer; a query is accepted only while
// the second slot is free, so a stalled rsp_ side never drops a result.
// Reset clears control state only; palette entries are undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_colour_euclid_top
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = NPC_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [NPC_REQ_DATA_W-1:0] req_tdata,  // entry_index, red, green, blue
   input  logic                      req_tuser,  // req_type
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [NPC_RSP_DATA_W-1:0] rsp_tdata   // nearest_index
);

   npc_state_type              state_ff;
   npc_state_type              state_in;
   logic                       req_accept;
   logic                       query_acc;
   logic                       load_en;
   npc_rgb_type                req_rgb;
   npc_probe_type              head_probe;
   npc_probe_type              tail_probe;
   logic                       done;
   logic                       rsp_pop;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [NPC_RSP_DATA_W-1:0]  rsp_data_ff;
   logic [NPC_RSP_DATA_W-1:0]  rsp_data_in;
   logic                       skid_valid_ff;
   logic                       skid_valid_in;
   logic [NPC_RSP_DATA_W-1:0]  skid_data_ff;
   logic [NPC_RSP_DATA_W-1:0]  skid_data_in;

   assign req_rgb.red   = req_tdata[NPC_INDEX_W +: NPC_CHAN_W];
   assign req_rgb.green = req_tdata[NPC_INDEX_W + NPC_CHAN_W +: NPC_CHAN_W];
   assign req_rgb.blue  = req_tdata[NPC_INDEX_W + 2 * NPC_CHAN_W +: NPC_CHAN_W];

   assign req_accept = req_tvalid && req_tready;
   assign query_acc  = req_accept && (npc_req_type'(req_tuser) == NPC_REQ_QUERY);
   assign load_en    = req_accept && (npc_req_type'(req_tuser) == NPC_REQ_LOAD);
   assign done       = tail_probe.valid;
   assign rsp_pop    = rsp_valid_ff && rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         NPC_IDLE: begin
            if (query_acc) begin
               state_in = NPC_SEARCH;
            end
         end
         NPC_SEARCH: begin
            if (done) begin
               state_in = NPC_IDLE;
            end
         end
         default: state_in = NPC_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      unique case (state_ff)
         NPC_IDLE:   req_tready = !skid_valid_ff;
         NPC_SEARCH: req_tready = 1'b0;
         default:    req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NPC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      head_probe.valid     = query_acc;
      head_probe.colour    = req_rgb;
      head_probe.best_dist = NPC_DIST_START;
      head_probe.best_idx  = '0;
   end

   npc_chain #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .load_index (req_tdata[NPC_INDEX_W-1:0]),
      .load_rgb   (req_rgb),
      .head_probe (head_probe),
      .tail_probe (tail_probe)
   );

   // output buffer: advance skid into the result register, then park a new item
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_pop) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (done) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tail_probe.best_idx;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = tail_probe.best_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == NPC_SEARCH)
      else $error("query left the cell row outside a search");

   a_done_skid_free: assert property (@(posedge clock) disable iff (reset)
      done |-> !skid_valid_ff)
      else $error("result arrived with no free output slot");

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds an item ahead of the result register");

   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      query_acc |=> !req_tready)
      else $error("item accepted while a query is in the cell row");

endmodule
